/* hw/rtl/gds_pkg.sv */
package gds_pkg;

  localparam logic [15:0] MIN_YEAR = 16'd1900;
  localparam logic [15:0] TOP_YEAR = 16'hFFFF;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;
  localparam logic [4:0] DAY_FIRST = 5'd1;
  localparam logic [4:0] DAY_LAST  = 5'd31;

  // Multiplicative inverse of 25 modulo 2^16; y is a multiple of 25 exactly
  // when y times the inverse, taken modulo 2^16, is no more than 65535 / 25.
  localparam logic [15:0] INV25     = 16'd23593;
  localparam logic [15:0] DIV25_MAX = 16'(65535 / 25);

  typedef enum logic [1:0] {
    CMD_SET  = 2'd0,
    CMD_UP   = 2'd1,
    CMD_DOWN = 2'd2,
    CMD_NONE = 2'd3
  } gds_cmd_t;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_REJECT = 2'd1,
    ST_LIMIT  = 2'd2
  } gds_status_t;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_REJECT,
    OP_UP,
    OP_DOWN,
    OP_KEEP
  } gds_op_t;

  typedef struct packed {
    gds_op_t     op;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [15:0] year;
    logic [11:0] count;
  } gds_entry_t;

  function automatic logic is_leap(input logic [15:0] y);
    logic [31:0] prod;
    logic        div25;
    prod  = 32'(y) * 32'(INV25);
    div25 = (prod[15:0] <= DIV25_MAX);
    // Divisible by 100 is divisible by 4 and by 25; by 400 adds 16.
    return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
  endfunction

  function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
    logic [4:0] d;
    case (m) inside
      MONTH_FEB:                   d = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:     d = 5'd30;
      default:                     d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

/* hw/rtl/gds_if.sv */
interface gds_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [4:0]  day_in;
  logic [3:0]  month_in;
  logic [15:0] year_in;
  logic [11:0] step_count;

  modport source (output valid, command, day_in, month_in, year_in, step_count,
                  input ready);
  modport sink (input valid, command, day_in, month_in, year_in, step_count,
                output ready);
endinterface

interface gds_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  day_out;
  logic [3:0]  month_out;
  logic [15:0] year_out;
  logic [1:0]  status;

  modport source (output valid, day_out, month_out, year_out, status,
                  input ready);
  modport sink (input valid, day_out, month_out, year_out, status,
                output ready);
endinterface

/* hw/rtl/gds_front.sv */
module gds_front (
  gds_in_if.sink               in_chan,
  output logic                 push_valid,
  input  logic                 push_ready,
  output gds_pkg::gds_entry_t  push_entry
);
  import gds_pkg::*;

  logic     date_ok;
  gds_cmd_t cmd;

  assign cmd = gds_cmd_t'(in_chan.command);

  assign date_ok = (in_chan.year_in >= MIN_YEAR) &&
                   (in_chan.month_in >= MONTH_JAN) && (in_chan.month_in <= MONTH_DEC) &&
                   (in_chan.day_in >= DAY_FIRST) &&
                   (in_chan.day_in <= days_in(in_chan.month_in, is_leap(in_chan.year_in)));

  always_comb begin
    push_entry.day   = in_chan.day_in;
    push_entry.month = in_chan.month_in;
    push_entry.year  = in_chan.year_in;
    push_entry.count = in_chan.step_count;
    unique case (cmd)
      CMD_SET:  push_entry.op = date_ok ? OP_LOAD : OP_REJECT;
      CMD_UP:   push_entry.op = (in_chan.step_count == 12'd0) ? OP_KEEP : OP_UP;
      CMD_DOWN: push_entry.op = (in_chan.step_count == 12'd0) ? OP_KEEP : OP_DOWN;
      default:  push_entry.op = OP_KEEP;
    endcase
  end

  assign push_valid    = in_chan.valid;
  assign in_chan.ready = push_ready;

endmodule

/* hw/rtl/gds_queue.sv */
module gds_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  gds_pkg::gds_entry_t  push_entry,
  output logic                 pop_valid,
  input  logic                 pop,
  output gds_pkg::gds_entry_t  pop_entry
);
  import gds_pkg::*;

  gds_entry_t entries_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] fill_r;
  logic       do_push, do_pop;

  assign push_ready = (fill_r != 2'd2);
  assign pop_valid  = (fill_r != 2'd0);
  assign pop_entry  = entries_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
      fill_r <= 2'(fill_r + {1'b0, do_push} - {1'b0, do_pop});
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entries_r[wr_ptr_r] <= push_entry;
  end

endmodule

/* hw/rtl/gds_back.sv */
module gds_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 pop_valid,
  output logic                 pop,
  input  gds_pkg::gds_entry_t  pop_entry,
  gds_out_if.source            out_chan
);
  import gds_pkg::*;

  typedef enum logic {S_IDLE, S_STEP} state_t;

  state_t      state_r, state_nxt;
  logic [11:0] cnt_r, cnt_nxt;
  logic        up_r, up_nxt;
  logic [4:0]  day_r, day_nxt;
  logic [3:0]  month_r, month_nxt;
  logic [15:0] year_r, year_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [4:0]  out_day_r, out_day_nxt;
  logic [3:0]  out_month_r, out_month_nxt;
  logic [15:0] out_year_r, out_year_nxt;
  gds_status_t out_status_r, out_status_nxt;

  logic        leap, slot_free, moved, is_step, last;
  logic [4:0]  dim, st_day;
  logic [3:0]  st_month;
  logic [15:0] st_year;

  assign leap      = is_leap(year_r);
  assign dim       = days_in(month_r, leap);
  assign slot_free = !out_valid_r || out_chan.ready;

  // One day forward or back from the current date.
  always_comb begin
    st_day   = day_r;
    st_month = month_r;
    st_year  = year_r;
    moved    = 1'b1;
    if (up_r) begin
      if (day_r < dim) begin
        st_day = 5'(day_r + 5'd1);
      end else if (month_r < MONTH_DEC) begin
        st_month = 4'(month_r + 4'd1);
        st_day   = DAY_FIRST;
      end else if (year_r == TOP_YEAR) begin
        moved = 1'b0;
      end else begin
        st_year  = 16'(year_r + 16'd1);
        st_month = MONTH_JAN;
        st_day   = DAY_FIRST;
      end
    end else begin
      if (day_r > DAY_FIRST) begin
        st_day = 5'(day_r - 5'd1);
      end else if (month_r > MONTH_JAN) begin
        st_month = 4'(month_r - 4'd1);
        st_day   = days_in(4'(month_r - 4'd1), leap);
      end else if (year_r <= MIN_YEAR) begin
        moved = 1'b0;
      end else begin
        st_year  = 16'(year_r - 16'd1);
        st_month = MONTH_DEC;
        st_day   = DAY_LAST;
      end
    end
  end

  assign is_step = (pop_entry.op == OP_UP) || (pop_entry.op == OP_DOWN);
  assign last    = !moved || (cnt_r == 12'd1);
  assign pop     = (state_r == S_IDLE) && pop_valid && (is_step || slot_free);

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    up_nxt         = up_r;
    day_nxt        = day_r;
    month_nxt      = month_r;
    year_nxt       = year_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_day_nxt    = out_day_r;
    out_month_nxt  = out_month_r;
    out_year_nxt   = out_year_r;
    out_status_nxt = out_status_r;
    unique case (state_r)
      S_IDLE: begin
        if (pop) begin
          if (is_step) begin
            cnt_nxt   = pop_entry.count;
            up_nxt    = (pop_entry.op == OP_UP);
            state_nxt = S_STEP;
          end else begin
            out_valid_nxt  = 1'b1;
            out_day_nxt    = day_r;
            out_month_nxt  = month_r;
            out_year_nxt   = year_r;
            out_status_nxt = (pop_entry.op == OP_REJECT) ? ST_REJECT : ST_DONE;
            if (pop_entry.op == OP_LOAD) begin
              day_nxt       = pop_entry.day;
              month_nxt     = pop_entry.month;
              year_nxt      = pop_entry.year;
              out_day_nxt   = pop_entry.day;
              out_month_nxt = pop_entry.month;
              out_year_nxt  = pop_entry.year;
            end
          end
        end
      end
      S_STEP: begin
        if (!last) begin
          day_nxt   = st_day;
          month_nxt = st_month;
          year_nxt  = st_year;
          cnt_nxt   = 12'(cnt_r - 12'd1);
        end else if (slot_free) begin
          // A blocked step leaves the date where it is and drops the rest.
          day_nxt        = st_day;
          month_nxt      = st_month;
          year_nxt       = st_year;
          out_valid_nxt  = 1'b1;
          out_day_nxt    = st_day;
          out_month_nxt  = st_month;
          out_year_nxt   = st_year;
          out_status_nxt = moved ? ST_DONE : ST_LIMIT;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      day_r       <= DAY_FIRST;
      month_r     <= MONTH_JAN;
      year_r      <= MIN_YEAR;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      day_r       <= day_nxt;
      month_r     <= month_nxt;
      year_r      <= year_nxt;
    end
    cnt_r        <= cnt_nxt;
    up_r         <= up_nxt;
    out_day_r    <= out_day_nxt;
    out_month_r  <= out_month_nxt;
    out_year_r   <= out_year_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.day_out   = out_day_r;
  assign out_chan.month_out = out_month_r;
  assign out_chan.year_out  = out_year_r;
  assign out_chan.status    = out_status_r;

endmodule

/* hw/rtl/gregorian_date_stepper.sv */
// Each accepted item gives one result; a step by n days moves the date n days, or fewer
// if a date limit stops it. Throughput: one set item per cycle while the output is ready;
// a step holds the stepping unit until its result is registered. The stepping unit moves
// the date by one day per cycle, the last one only once the output register is free; a
// two-item queue lets new items enter while it works. Synchronous active-low reset sets
// the date to 1/1/1900 and empties the queue and the output register.
module gregorian_date_stepper (
  input  logic       clk,
  input  logic       rst_n,
  gds_in_if.sink     in_chan,
  gds_out_if.source  out_chan
);
  import gds_pkg::*;

  logic       push_valid, push_ready, pop_valid, pop;
  gds_entry_t push_entry, pop_entry;

  gds_front u_front (
    .in_chan    (in_chan),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  gds_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_entry  (pop_entry)
  );

  gds_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop       (pop),
    .pop_entry (pop_entry),
    .out_chan  (out_chan)
  );

endmodule
